// ----- hw/rtl/array_list_engine_unit_assert.svh -----
// Assertion macros for the array list engine.
// Included by the modules that check their own control logic.
`ifndef ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ALE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array list engine check failed");
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array list engine check failed");
`else
`define ALE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/ale_pkg.sv -----
// Shared constants, codes and bundle types of the array list engine.
// No dependencies.
package ale_pkg;

    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int AW        = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int FIELD_W   = 9;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 9;
    localparam int CAP_RESET = 256;
    localparam int CMP_W     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOCATE = 2'd2,
        FN_SEARCH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_func                func;
        logic [FIELD_W-1:0]   pos;
        t_word                word;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   index;
        logic [FIELD_W-1:0]   length;
        logic                 empty;
    } t_res;

    typedef struct packed {
        logic                 we;
        logic [AW-1:0]        waddr;
        t_word                wdata;
        logic                 re;
        logic [AW-1:0]        raddr;
    } t_mem_req;

    function automatic t_word to_word(logic signed [VAL_W-1:0] v);
        t_word w;
        w = WORD_BITS'(v);
        return w;
    endfunction

endpackage

// ----- hw/rtl/ale_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ale_ctrl.sv -----
// Request sequencer of the array list engine: shift, scan and halving search
// over the entry RAM. Depends on ale_pkg and array_list_engine_unit_assert.svh.
`include "array_list_engine_unit_assert.svh"
module ale_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ale_pkg::t_req              i_req,
    input  logic [ale_pkg::CAP_W-1:0]  i_cap,
    input  ale_pkg::t_word             i_rdata,
    output ale_pkg::t_mem_req          o_mem,
    output logic                       o_busy,
    output logic                       o_valid,
    output ale_pkg::t_res              o_res
);

    localparam int CW = ale_pkg::CNT_W;
    localparam int MW = ale_pkg::CMP_W;
    localparam int FW = ale_pkg::FIELD_W;
    localparam int AW = ale_pkg::AW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_LOC_RD,
        S_LOC_CMP,
        S_BS_RD,
        S_BS_CMP
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_q, n_q;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi1, n_hi1;
    logic [CW-1:0]         r_mid, n_mid;
    ale_pkg::t_word        r_word, n_word;
    logic                  r_valid, n_valid;
    ale_pkg::t_res         r_res, n_res;

    logic                  full;
    logic                  ins_bad;
    logic                  del_bad;
    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid;
    logic [CW-1:0]         q_next;

    assign full    = (MW'(r_count) >= MW'(i_cap)) || (r_count >= CW'(ale_pkg::DEPTH));
    assign ins_bad = MW'(i_req.pos) > MW'(r_count);
    assign del_bad = MW'(i_req.pos) >= MW'(r_count);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi1} - (CW + 1)'(1);
    assign mid     = mid_sum[CW:1];
    assign q_next  = r_q + CW'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_q     = r_q;
        n_pos   = r_pos;
        n_lo    = r_lo;
        n_hi1   = r_hi1;
        n_mid   = r_mid;
        n_word  = r_word;
        n_valid = 1'b0;
        n_res   = r_res;
        o_mem   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_word = i_req.word;
                    n_pos  = CW'(i_req.pos);
                    n_res.length = FW'(r_count);
                    n_res.empty  = (r_count == '0);
                    n_res.index  = '0;
                    case (i_req.func)
                        ale_pkg::FN_INSERT: begin
                            if (full) begin
                                n_valid = 1'b1;
                                n_res.status = ale_pkg::ST_FULL;
                            end else if (ins_bad) begin
                                n_valid = 1'b1;
                                n_res.status = ale_pkg::ST_BADPOS;
                            end else begin
                                n_q     = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        ale_pkg::FN_DELETE: begin
                            if (del_bad) begin
                                n_valid = 1'b1;
                                n_res.status = ale_pkg::ST_BADPOS;
                            end else begin
                                n_q     = CW'(i_req.pos);
                                n_state = S_DEL_RD;
                            end
                        end
                        ale_pkg::FN_LOCATE: begin
                            n_q     = '0;
                            n_state = S_LOC_RD;
                        end
                        default: begin
                            n_lo    = '0;
                            n_hi1   = r_count;
                            n_state = S_BS_RD;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_q > r_pos) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = AW'(r_q - CW'(1));
                    n_state     = S_INS_WR;
                end else begin
                    o_mem.we     = 1'b1;
                    o_mem.waddr  = AW'(r_pos);
                    o_mem.wdata  = r_word;
                    n_count      = r_count + CW'(1);
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_OK;
                    n_res.index  = FW'(r_pos);
                    n_res.length = FW'(r_count + CW'(1));
                    n_res.empty  = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = AW'(r_q);
                o_mem.wdata = i_rdata;
                n_q         = r_q - CW'(1);
                n_state     = S_INS_RD;
            end
            S_DEL_RD: begin
                if (q_next < r_count) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = AW'(q_next);
                    n_state     = S_DEL_WR;
                end else begin
                    n_count      = r_count - CW'(1);
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_OK;
                    n_res.index  = FW'(r_pos);
                    n_res.length = FW'(r_count - CW'(1));
                    n_res.empty  = (r_count == CW'(1));
                    n_state      = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = AW'(r_q);
                o_mem.wdata = i_rdata;
                n_q         = q_next;
                n_state     = S_DEL_RD;
            end
            S_LOC_RD: begin
                if (r_q < r_count) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = AW'(r_q);
                    n_state     = S_LOC_CMP;
                end else begin
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_NOTFOUND;
                    n_res.index  = '0;
                    n_state      = S_IDLE;
                end
            end
            S_LOC_CMP: begin
                if (i_rdata == r_word) begin
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_OK;
                    n_res.index  = FW'(r_q);
                    n_state      = S_IDLE;
                end else begin
                    n_q     = q_next;
                    n_state = S_LOC_RD;
                end
            end
            S_BS_RD: begin
                if (r_lo < r_hi1) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = AW'(mid);
                    n_mid       = mid;
                    n_state     = S_BS_CMP;
                end else begin
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_NOTFOUND;
                    n_res.index  = FW'(r_lo);
                    n_state      = S_IDLE;
                end
            end
            S_BS_CMP: begin
                if (i_rdata == r_word) begin
                    n_valid      = 1'b1;
                    n_res.status = ale_pkg::ST_OK;
                    n_res.index  = FW'(r_mid);
                    n_state      = S_IDLE;
                end else if ($signed(i_rdata) > $signed(r_word)) begin
                    n_hi1   = r_mid;
                    n_state = S_BS_RD;
                end else begin
                    n_lo    = r_mid + CW'(1);
                    n_state = S_BS_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_q    <= n_q;
        r_pos  <= n_pos;
        r_lo   <= n_lo;
        r_hi1  <= n_hi1;
        r_mid  <= n_mid;
        r_word <= n_word;
        r_res  <= n_res;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `ALE_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(ale_pkg::DEPTH))
    `ALE_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    `ALE_ASSERT_IMP(a_count_moves, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_count), r_valid)

endmodule

// ----- hw/rtl/array_list_engine_unit.sv -----
// Top level of the array list engine: APB capacity register, sequencer, RAM.
// Depends on ale_pkg, ale_ram and ale_ctrl.
//
//   channel   | handshake                           | payload
//   ----------+-------------------------------------+----------------------------------
//   request   | start, busy (taken: start & !busy)  | i_func, i_position, i_value
//   result    | o_valid, one cycle, no back-pressure| o_status, o_index, o_length,
//             |                                     | o_empty_res
//   config    | psel, penable, pwrite, pready       | paddr, pwdata, prdata
//
// Insert shifts the entries from the position up, then writes the new value; delete
// shifts the entries after the position down; locate scans from index 0; binary search
// halves the range; a full or bad-position request answers from idle. Each moved or
// examined entry costs a RAM read and a write or compare step on the single entry RAM.
// o_valid rises the cycle after a request ends; a new request may start in that cycle.
// Reset clears the length and sets capacity to 256; entry contents are not cleared.
module array_list_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [ale_pkg::FIELD_W-1:0]  i_position,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [ale_pkg::FIELD_W-1:0]  o_index,
    output logic [ale_pkg::FIELD_W-1:0]  o_length,
    output logic                         o_empty_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CPW = ale_pkg::CAP_W;

    logic [CPW-1:0]     r_cap;
    logic               cfg_wr;
    ale_pkg::t_req      req;
    ale_pkg::t_res      res;
    ale_pkg::t_mem_req  mem;
    ale_pkg::t_word     rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CPW'(ale_pkg::CAP_RESET);
        end else if (cfg_wr) begin
            r_cap <= pwdata[CPW-1:0];
        end
    end

    assign req.func = ale_pkg::t_func'(i_func);
    assign req.pos  = i_position;
    assign req.word = ale_pkg::to_word(i_value);

    ale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .i_cap   (r_cap),
        .i_rdata (rdata),
        .o_mem   (mem),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (res)
    );

    ale_ram #(
        .WIDTH (ale_pkg::WORD_BITS),
        .DEPTH (ale_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    assign o_status    = res.status;
    assign o_index     = res.index;
    assign o_length    = res.length;
    assign o_empty_res = res.empty;

endmodule
